@@ rtl/core/lca_pkg.sv @@
// shared types and constants of the lowest common ancestor engine
// table geometry, command and status words between controller and datapath
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int LEVELS      = 10;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int DEPTH_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int STEP_W      = $clog2(((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1);
   localparam int ADDR_W      = LVL_W + NODE_W;
   localparam int TABLE_DEPTH = LEVELS * MAX_NODES;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BUILD = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      RES_ZERO   = 2'd0,
      RES_A      = 2'd1,
      RES_PARENT = 2'd2
   } res_sel_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] target;
   } entry_type;

   typedef struct packed {
      logic        clr_step;
      logic        load_wr;
      logic        start_query;
      logic        order;
      logic        lift_rd;
      logic        lift_take;
      logic        shift;
      logic        jump_init;
      logic        jump_rd;
      logic        jump_take;
      logic        step_dec;
      logic        final_rd;
      logic        build_init;
      logic        build_rd_low;
      logic        build_rd_up;
      logic        build_wr;
      logic        build_wr_empty;
      logic        build_next;
      logic        emit;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic build_none;
      logic build_done;
      logic low_valid;
      logic diff_zero;
      logic diff_lsb;
      logic step_beyond;
      logic step_zero;
      logic a_eq_b;
      logic jump_cross;
      logic jump_broken;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/lowest_common_ancestor_lifting.sv @@
// top level of the lowest common ancestor engine: controller plus datapath
// depends on lca_pkg, lca_ctrl, lca_datapath
//
// usage
//   command channel: a word is taken at a rising edge with start high and busy low.
//   mode load writes a node's direct parent (or root mark) and its depth. mode
//   build fills the 2^k ancestor table for nodes 2 to node_count (node_count
//   clamped to MAX_NODES-1), (LEVELS-1)*(node_count-1) entries. mode query gives
//   two nodes; its result word shows on rsp_ancestor with rsp_strobe high for
//   exactly one cycle. mode 3 is taken and does nothing.
//   query sequence: depths are fetched at the accept edge, then the nodes are
//   ordered, the depth difference is lifted bit by bit (a shift for a zero bit,
//   a table read and a take for a set bit) until it is seen to be zero, paired
//   jump reads run from the top level down, a parent step reads level 0 and the
//   output register holds the result word. the next word can be taken at the
//   edge that takes the result.
//   the receiver cannot stall: a result word is valid for its one cycle only.
//   csr channel: node_count is written whenever csr_valid is high; csr_ready
//   stays high. write it only while the engine is idle.
//   reset: node_count returns to 1 and the ancestor table is swept to empty,
//   one entry a cycle over all LEVELS*MAX_NODES = 10240 entries, with busy held high.
//   depths of nodes never loaded are undefined.
`timescale 1ns / 1ps
`default_nettype none

module lowest_common_ancestor_lifting (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [1:0]                        req_mode,
   input  wire [lca_pkg::NODE_W-1:0]        req_node,
   input  wire [lca_pkg::NODE_W-1:0]        req_parent_node,
   input  wire                              req_has_parent,
   input  wire [lca_pkg::DEPTH_W-1:0]       req_node_level,
   input  wire [lca_pkg::NODE_W-1:0]        req_other_node,
   output logic                             rsp_strobe,
   output logic [lca_pkg::NODE_W-1:0]       rsp_ancestor,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [lca_pkg::COUNT_W-1:0]       csr_node_count
);

   lca_pkg::cmd_type    cmd;
   lca_pkg::status_type status;

   assign csr_ready = 1'b1;

   lca_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   lca_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_node        (req_node),
      .req_parent_node (req_parent_node),
      .req_has_parent  (req_has_parent),
      .req_node_level  (req_node_level),
      .req_other_node  (req_other_node),
      .csr_we          (csr_valid & csr_ready),
      .csr_node_count  (csr_node_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_ancestor    (rsp_ancestor)
   );

endmodule

`default_nettype wire

@@ rtl/core/lca_datapath.sv @@
// datapath of the lowest common ancestor engine: jump table, depth store,
// node and step registers, result register and node count register
// depends on lca_pkg
`timescale 1ns / 1ps
`default_nettype none

module lca_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire lca_pkg::cmd_type            cmd,
   output lca_pkg::status_type              status,
   input  wire [lca_pkg::NODE_W-1:0]        req_node,
   input  wire [lca_pkg::NODE_W-1:0]        req_parent_node,
   input  wire                              req_has_parent,
   input  wire [lca_pkg::DEPTH_W-1:0]       req_node_level,
   input  wire [lca_pkg::NODE_W-1:0]        req_other_node,
   input  wire                              csr_we,
   input  wire [lca_pkg::COUNT_W-1:0]       csr_node_count,
   output logic                             rsp_strobe,
   output logic [lca_pkg::NODE_W-1:0]       rsp_ancestor
);

   lca_pkg::entry_type jump_mem [lca_pkg::TABLE_DEPTH];
   logic [lca_pkg::DEPTH_W-1:0] level_mem [lca_pkg::MAX_NODES];

   logic [lca_pkg::COUNT_W-1:0] node_count_ff, node_count_in;
   logic [lca_pkg::ADDR_W-1:0]  clr_ff, clr_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [lca_pkg::NODE_W-1:0]  ancestor_ff, ancestor_in;
   logic [lca_pkg::NODE_W-1:0]  a_ff, a_in;
   logic [lca_pkg::NODE_W-1:0]  b_ff, b_in;
   logic [lca_pkg::DEPTH_W-1:0] diff_ff, diff_in;
   logic [lca_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [lca_pkg::LVL_W-1:0]   k_ff, k_in;
   logic [lca_pkg::NODE_W-1:0]  j_ff, j_in;
   lca_pkg::entry_type          rd_a_ff, rd_b_ff;
   logic [lca_pkg::DEPTH_W-1:0] lvl_a_ff, lvl_b_ff;

   logic [lca_pkg::NODE_W-1:0]  last_node;
   logic [lca_pkg::LVL_W-1:0]   k_low;
   logic [lca_pkg::LVL_W-1:0]   step_lvl;
   logic                        rd_a_en, rd_b_en, wr_en;
   logic [lca_pkg::ADDR_W-1:0]  rd_a_addr, rd_b_addr, wr_addr;
   lca_pkg::entry_type          wr_data;

   assign last_node = (node_count_ff > lca_pkg::COUNT_W'(lca_pkg::MAX_NODES - 1))
                      ? lca_pkg::NODE_W'(lca_pkg::MAX_NODES - 1)
                      : node_count_ff[lca_pkg::NODE_W-1:0];
   assign k_low    = k_ff - lca_pkg::LVL_W'(1);
   assign step_lvl = step_ff[lca_pkg::LVL_W-1:0];

   // table port selection
   always_comb begin
      rd_a_en   = cmd.lift_rd | cmd.jump_rd | cmd.final_rd | cmd.build_rd_low;
      rd_b_en   = cmd.jump_rd | cmd.build_rd_up;
      rd_a_addr = {step_lvl, a_ff};
      rd_b_addr = {step_lvl, b_ff};
      wr_en     = cmd.clr_step | cmd.load_wr | cmd.build_wr | cmd.build_wr_empty;
      wr_addr   = clr_ff;
      wr_data   = '0;
      if (cmd.final_rd) begin
         rd_a_addr = {lca_pkg::LVL_W'(0), a_ff};
      end else if (cmd.build_rd_low) begin
         rd_a_addr = {k_low, j_ff};
      end
      if (cmd.build_rd_up) begin
         rd_b_addr = {k_low, rd_a_ff.target};
      end
      priority if (cmd.load_wr) begin
         wr_addr        = {lca_pkg::LVL_W'(0), req_node};
         wr_data.valid  = req_has_parent;
         wr_data.target = req_has_parent ? req_parent_node : '0;
      end else if (cmd.build_wr) begin
         wr_addr = {k_ff, j_ff};
         wr_data = rd_b_ff;
      end else if (cmd.build_wr_empty) begin
         wr_addr = {k_ff, j_ff};
      end else begin
         wr_addr = clr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         jump_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_ff <= jump_mem[rd_a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_b_en) begin
         rd_b_ff <= jump_mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         level_mem[req_node] <= req_node_level;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         lvl_a_ff <= level_mem[req_node];
         lvl_b_ff <= level_mem[req_other_node];
      end
   end

   // next values of the working registers
   always_comb begin
      node_count_in = csr_we ? csr_node_count : node_count_ff;
      clr_in        = cmd.clr_step ? clr_ff + lca_pkg::ADDR_W'(1) : clr_ff;
      rsp_strobe_in = cmd.emit;
      ancestor_in   = ancestor_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      diff_in       = diff_ff;
      step_in       = step_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      if (cmd.emit) begin
         unique case (cmd.res_sel)
            lca_pkg::RES_ZERO:   ancestor_in = '0;
            lca_pkg::RES_A:      ancestor_in = a_ff;
            lca_pkg::RES_PARENT: ancestor_in = rd_a_ff.valid ? rd_a_ff.target : '0;
            default:             ancestor_in = '0;
         endcase
      end
      if (cmd.start_query) begin
         a_in = req_node;
         b_in = req_other_node;
      end
      if (cmd.order) begin
         step_in = '0;
         if (lvl_a_ff < lvl_b_ff) begin
            a_in    = b_ff;
            b_in    = a_ff;
            diff_in = lvl_b_ff - lvl_a_ff;
         end else begin
            diff_in = lvl_a_ff - lvl_b_ff;
         end
      end
      if (cmd.lift_take) begin
         a_in = rd_a_ff.target;
      end
      if (cmd.shift) begin
         diff_in = diff_ff >> 1;
         step_in = step_ff + lca_pkg::STEP_W'(1);
      end
      if (cmd.jump_init) begin
         step_in = lca_pkg::STEP_W'(lca_pkg::LEVELS - 1);
      end
      if (cmd.jump_take) begin
         a_in = rd_a_ff.target;
         b_in = rd_b_ff.target;
      end
      if (cmd.step_dec) begin
         step_in = step_ff - lca_pkg::STEP_W'(1);
      end
      if (cmd.build_init) begin
         k_in = lca_pkg::LVL_W'(1);
         j_in = lca_pkg::NODE_W'(2);
      end
      if (cmd.build_next) begin
         if (j_ff == last_node) begin
            j_in = lca_pkg::NODE_W'(2);
            k_in = k_ff + lca_pkg::LVL_W'(1);
         end else begin
            j_in = j_ff + lca_pkg::NODE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= lca_pkg::COUNT_W'(1);
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ancestor_ff <= ancestor_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      diff_ff     <= diff_in;
      step_ff     <= step_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
   end

   always_comb begin
      status.clear_last  = (clr_ff == lca_pkg::ADDR_W'(lca_pkg::TABLE_DEPTH - 1));
      status.build_none  = (node_count_ff < lca_pkg::COUNT_W'(2)) || (lca_pkg::LEVELS < 2);
      status.build_done  = (j_ff == last_node)
                           && (k_ff == lca_pkg::LVL_W'(lca_pkg::LEVELS - 1));
      status.low_valid   = rd_a_ff.valid;
      status.diff_zero   = (diff_ff == '0);
      status.diff_lsb    = diff_ff[0];
      status.step_beyond = (step_ff >= lca_pkg::STEP_W'(lca_pkg::LEVELS));
      status.step_zero   = (step_ff == '0);
      status.a_eq_b      = (a_ff == b_ff);
      status.jump_cross  = rd_a_ff.valid
                           && (!rd_b_ff.valid || (rd_a_ff.target != rd_b_ff.target));
      status.jump_broken = !rd_b_ff.valid;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_ancestor = ancestor_ff;

`ifndef SYNTHESIS
   a_lift_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.lift_rd |-> (step_ff < lca_pkg::STEP_W'(lca_pkg::LEVELS)))
      else $error("lift read beyond top level");

   a_build_level: assert property (@(posedge clock) disable iff (reset)
      (cmd.build_wr || cmd.build_wr_empty) |-> (k_ff != '0))
      else $error("build writes level zero");

   a_jump_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.jump_take |-> (rd_a_ff.valid && rd_b_ff.valid))
      else $error("jump taken on empty entry");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back to back result words");
`endif

endmodule

`default_nettype wire

@@ rtl/core/lca_ctrl.sv @@
// controller of the lowest common ancestor engine: clear pass, load,
// build sweep and query sequencing as a one-hot state machine
// depends on lca_pkg
`timescale 1ns / 1ps
`default_nettype none

module lca_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire [1:0]                req_mode,
   input  wire lca_pkg::status_type status,
   output lca_pkg::cmd_type         cmd,
   output logic                     busy
);

   typedef enum logic [12:0] {
      ST_CLEAR      = 13'b0000000000001,
      ST_IDLE       = 13'b0000000000010,
      ST_ORDER      = 13'b0000000000100,
      ST_LIFT       = 13'b0000000001000,
      ST_LIFT_WAIT  = 13'b0000000010000,
      ST_JUMP_RD    = 13'b0000000100000,
      ST_JUMP_WAIT  = 13'b0000001000000,
      ST_FINAL_RD   = 13'b0000010000000,
      ST_FINAL_WAIT = 13'b0000100000000,
      ST_BUILD_RD   = 13'b0001000000000,
      ST_BUILD_LOW  = 13'b0010000000000,
      ST_BUILD_UP   = 13'b0100000000000,
      ST_SPARE      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (lca_pkg::mode_type'(req_mode))
                  lca_pkg::MODE_LOAD: begin
                     cmd.load_wr = 1'b1;
                  end
                  lca_pkg::MODE_BUILD: begin
                     if (!status.build_none) begin
                        cmd.build_init = 1'b1;
                        state_in       = ST_BUILD_RD;
                     end
                  end
                  lca_pkg::MODE_QUERY: begin
                     cmd.start_query = 1'b1;
                     state_in        = ST_ORDER;
                  end
                  lca_pkg::MODE_NONE: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ORDER: begin
            cmd.order = 1'b1;
            state_in  = ST_LIFT;
         end
         ST_LIFT: begin
            priority if (status.diff_zero) begin
               if (status.a_eq_b) begin
                  cmd.emit    = 1'b1;
                  cmd.res_sel = lca_pkg::RES_A;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.jump_init = 1'b1;
                  state_in      = ST_JUMP_RD;
               end
            end else if (status.diff_lsb) begin
               if (status.step_beyond) begin
                  cmd.emit    = 1'b1;
                  cmd.res_sel = lca_pkg::RES_ZERO;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.lift_rd = 1'b1;
                  state_in    = ST_LIFT_WAIT;
               end
            end else begin
               cmd.shift = 1'b1;
            end
         end
         ST_LIFT_WAIT: begin
            if (!status.low_valid) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = lca_pkg::RES_ZERO;
               state_in    = ST_IDLE;
            end else begin
               cmd.lift_take = 1'b1;
               cmd.shift     = 1'b1;
               state_in      = ST_LIFT;
            end
         end
         ST_JUMP_RD: begin
            cmd.jump_rd = 1'b1;
            state_in    = ST_JUMP_WAIT;
         end
         ST_JUMP_WAIT: begin
            if (status.jump_cross && status.jump_broken) begin
               cmd.emit    = 1'b1;
               cmd.res_sel = lca_pkg::RES_ZERO;
               state_in    = ST_IDLE;
            end else begin
               cmd.jump_take = status.jump_cross;
               if (status.step_zero) begin
                  state_in = ST_FINAL_RD;
               end else begin
                  cmd.step_dec = 1'b1;
                  state_in     = ST_JUMP_RD;
               end
            end
         end
         ST_FINAL_RD: begin
            cmd.final_rd = 1'b1;
            state_in     = ST_FINAL_WAIT;
         end
         ST_FINAL_WAIT: begin
            cmd.emit    = 1'b1;
            cmd.res_sel = lca_pkg::RES_PARENT;
            state_in    = ST_IDLE;
         end
         ST_BUILD_RD: begin
            cmd.build_rd_low = 1'b1;
            state_in         = ST_BUILD_LOW;
         end
         ST_BUILD_LOW: begin
            if (status.low_valid) begin
               cmd.build_rd_up = 1'b1;
               state_in        = ST_BUILD_UP;
            end else begin
               cmd.build_wr_empty = 1'b1;
               cmd.build_next     = 1'b1;
               state_in           = status.build_done ? ST_IDLE : ST_BUILD_RD;
            end
         end
         ST_BUILD_UP: begin
            cmd.build_wr   = 1'b1;
            cmd.build_next = 1'b1;
            state_in       = status.build_done ? ST_IDLE : ST_BUILD_RD;
         end
         ST_SPARE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire
